// ===== rtl/core/sbda_pkg.sv =====
// Package for the signed binary to decimal ASCII converter.
// Holds shared constants and the back-end state type; depends on nothing.
package sbda_pkg;

    // Width of the input number field and the widest supported value.
    localparam int NUMBER_BITS      = 32;
    localparam int MAX_VALUE_BITS   = 64;
    localparam int DEF_VALUE_BITS   = 32;

    // Character field and the characters produced.
    localparam int CHAR_BITS        = 7;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;

    // Decimal digit width and the threshold for the add-3 correction.
    localparam int DIGIT_BITS       = 4;
    localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DABBLE_ADD   = 4'd3;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH      = 2;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } t_back_state;

endpackage

// ===== rtl/core/sbda_num_if.sv =====
// Input channel carrying one signed number per transaction.
// Depends on sbda_pkg for the field width.
interface sbda_num_if
    import sbda_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

// ===== rtl/core/sbda_char_if.sv =====
// Output channel carrying one ASCII character per transaction.
// Depends on sbda_pkg for the character width.
interface sbda_char_if
    import sbda_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] text_char;
    logic                 last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ===== rtl/core/sbda_front.sv =====
// Front end: accepts numbers and splits them into sign and magnitude.
// Depends on sbda_pkg and sbda_num_if.
module sbda_front
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    sbda_num_if.sink          i_num,
    input  logic              i_full,
    output logic              o_push,
    output logic [VALUE_BITS:0] o_push_data
);

    logic [MAX_VALUE_BITS-1:0] w_ext;
    logic [VALUE_BITS-1:0]     w_value;
    logic                      w_neg;
    logic [VALUE_BITS-1:0]     w_mag;

    // Only the low VALUE_BITS bits count; a wider setting sees the field zero-extended.
    assign w_ext   = {{(MAX_VALUE_BITS-NUMBER_BITS){1'b0}}, i_num.number};
    assign w_value = w_ext[VALUE_BITS-1:0];

    // The magnitude is unsigned, so the most negative value needs no special case.
    assign w_neg = w_value[VALUE_BITS-1];
    assign w_mag = w_neg ? (~w_value + VALUE_BITS'(1)) : w_value;

    // A transaction is taken whenever the queue has room.
    assign i_num.ready = !i_full;
    assign o_push      = i_num.valid && !i_full;
    assign o_push_data = {w_neg, w_mag};

endmodule

// ===== rtl/core/sbda_queue.sv =====
// Short queue of classified numbers between the front and back ends.
// Depends on sbda_pkg for the default depth.
module sbda_queue
    import sbda_pkg::*;
#(
    parameter int WIDTH = DEF_VALUE_BITS + 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_entry [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_entry[r_rd_ptr];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && !o_empty;

    // Entry storage holds payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

    // A push into a non-full queue without a pop raises the count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count not raised on push");

    // Pointers are equal whenever the queue is empty.
    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers differ while empty");

endmodule

// ===== rtl/core/sbda_back.sv =====
// Back end: shift-add-3 conversion of the magnitude, then character output.
// Depends on sbda_pkg and sbda_char_if.
module sbda_back
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  logic [VALUE_BITS:0] i_job,
    output logic                o_job_pop,
    sbda_char_if.source         o_char
);

    // Decimal digits needed for VALUE_BITS bits: floor(VALUE_BITS*log10(2)) + 1.
    localparam int NDIG = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCDW = DIGIT_BITS * NDIG;
    localparam int CNTW = $clog2(VALUE_BITS);
    localparam int REMW = $clog2(NDIG + 1);

    t_back_state              r_state, n_state;
    logic [VALUE_BITS-1:0]    r_shift, n_shift;
    logic [BCDW-1:0]          r_bcd, n_bcd;
    logic                     r_neg, n_neg;
    logic [CNTW-1:0]          r_cnt, n_cnt;
    logic [REMW-1:0]          r_rem, n_rem;
    logic                     r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]     r_out_char, n_out_char;
    logic                     r_out_last, n_out_last;
    logic [BCDW-1:0]          w_adj;
    logic [DIGIT_BITS-1:0]    w_top;
    logic                     w_slot;

    // Add-3 correction on every digit; digits are independent of each other.
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            if (r_bcd[k*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT) begin
                w_adj[k*DIGIT_BITS +: DIGIT_BITS] =
                    r_bcd[k*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADD;
            end else begin
                w_adj[k*DIGIT_BITS +: DIGIT_BITS] = r_bcd[k*DIGIT_BITS +: DIGIT_BITS];
            end
        end
    end

    assign w_top  = r_bcd[BCDW-1 -: DIGIT_BITS];
    assign w_slot = !r_out_valid || o_char.ready;

    // Sequencer state and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_bcd      <= n_bcd;
        r_neg      <= n_neg;
        r_cnt      <= n_cnt;
        r_rem      <= n_rem;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // Next state: load, convert, skip leading zeros, emit sign and digits.
    always_comb begin
        n_state     = r_state;
        n_shift     = r_shift;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && !o_char.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_job_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_neg     = i_job[VALUE_BITS];
                    n_shift   = i_job[VALUE_BITS-1:0];
                    n_bcd     = '0;
                    n_cnt     = '0;
                    n_rem     = REMW'(NDIG);
                    n_state   = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd   = {w_adj[BCDW-2:0], r_shift[VALUE_BITS-1]};
                n_shift = {r_shift[VALUE_BITS-2:0], 1'b0};
                n_cnt   = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(VALUE_BITS-1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop one leading zero a cycle, keeping at least one digit.
                if (w_top == '0 && r_rem != REMW'(1)) begin
                    n_bcd = {r_bcd[BCDW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    n_rem = r_rem - REMW'(1);
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, w_top} + CHAR_ZERO;
                    n_out_last  = (r_rem == REMW'(1));
                    n_bcd       = {r_bcd[BCDW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    n_rem       = r_rem - REMW'(1);
                    if (r_rem == REMW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_char.valid     = r_out_valid;
    assign o_char.text_char = r_out_char;
    assign o_char.last_char = r_out_last;

    // The sign character is only ever produced for a negative number.
    a_sign_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN) |-> r_neg)
        else $error("sign state entered for a non-negative number");

    // Digit output always has at least one digit left to send.
    a_digit_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGIT || r_state == ST_SKIP) |-> (r_rem != '0))
        else $error("digit count exhausted while emitting");

    // Taking a job from the queue always starts a conversion.
    a_pop_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == ST_CONV && r_cnt == '0))
        else $error("job popped without starting conversion");

    // The last flag on the final digit coincides with the return to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGIT && w_slot && r_rem == REMW'(1))
            |=> (r_state == ST_IDLE && r_out_valid && r_out_last))
        else $error("final character not flagged on return to idle");

endmodule

// ===== rtl/core/signed_binary_to_decimal_ascii.sv =====
// Signed binary to decimal ASCII converter, one character per output transaction.
// Each number is loaded, converted by shift-add-3 over all VALUE_BITS bits, stripped of
// leading zeros but one, then sent a character at a time, a minus sign first for a
// negative number; output stalls hold the back end. The queue lets the next number enter
// meanwhile.
// Reset is synchronous and active low; it empties the queue and idles the back end.
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbda_num_if.sink    i_num,
    sbda_char_if.source o_char
);

    logic                w_full;
    logic                w_empty;
    logic                w_push;
    logic                w_pop;
    logic [VALUE_BITS:0] w_push_data;
    logic [VALUE_BITS:0] w_pop_data;

    // Classification of incoming numbers.
    sbda_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_num       (i_num),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Decoupling queue.
    sbda_queue #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    // Conversion and character output.
    sbda_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_empty),
        .i_job       (w_pop_data),
        .o_job_pop   (w_pop),
        .o_char      (o_char)
    );

endmodule
